@@ hw/rtl/wrps_pkg.sv @@
package wrps_pkg;

	localparam int DEF_MAX_PEERS   = 64;
	localparam int DEF_WEIGHT_BITS = 16;

	// Fixed field widths of the streaming and configuration ports.
	localparam int PEER_IDX_BITS   = 6;
	localparam int IN_WEIGHT_BITS  = 16;
	localparam int FRAC_BITS       = 16;
	localparam int PEER_COUNT_BITS = 7;
	localparam int CFG_INDEX_BITS  = 1;
	localparam int CFG_DATA_BITS   = 7;
	localparam int S_TDATA_BITS    = 40;
	localparam int M_TDATA_BITS    = 8;
	localparam int STATUS_BITS     = 2;

	// One weight unit with 8 fraction bits.
	localparam int ONE_UNIT = 256;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_SELECT = 1'b1
	} opcode_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STATUS_OK         = 2'd0,
		STATUS_OWN_RANK   = 2'd1,
		STATUS_ZERO_TOTAL = 2'd2
	} status_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PEER_COUNT = 1'b0,
		REG_OWN_RANK   = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MUL,
		ST_SEARCH,
		ST_DONE
	} scan_state_t;

	typedef struct packed {
		logic [PEER_COUNT_BITS-1:0] peer_count;
		logic [PEER_IDX_BITS-1:0]   own_rank;
		logic                       own_rank_wr;
		logic                       any_wr;
	} cfg_state_t;

endpackage

@@ hw/rtl/wrps_weight_store.sv @@
module wrps_weight_store #(
	parameter int MAX_PEERS   = wrps_pkg::DEF_MAX_PEERS,
	parameter int WEIGHT_BITS = wrps_pkg::DEF_WEIGHT_BITS,
	localparam int IDX_W      = $clog2(MAX_PEERS),
	localparam int CNT_W      = $clog2(MAX_PEERS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [IDX_W-1:0]       wr_addr,
	input  logic [WEIGHT_BITS-1:0] wr_data,
	input  logic                   rd_en,
	input  logic [IDX_W-1:0]       rd_addr,
	output logic [WEIGHT_BITS-1:0] rd_data,
	output logic                   init_done
);

	// One unit, saturated when the weight is too narrow to hold it.
	localparam logic [WEIGHT_BITS-1:0] RESET_WEIGHT = (WEIGHT_BITS > 8) ?
		WEIGHT_BITS'(wrps_pkg::ONE_UNIT) : {WEIGHT_BITS{1'b1}};

	logic [WEIGHT_BITS-1:0] mem [MAX_PEERS];
	logic [WEIGHT_BITS-1:0] rd_data_q;
	logic [CNT_W-1:0]       clr_cnt_q;
	logic                   init_done_q;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_addr;
	logic [WEIGHT_BITS-1:0] mem_wdata;

	// After reset the store is swept once so that every entry holds one unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			init_done_q <= 1'b0;
		end else if (!init_done_q) begin
			if (clr_cnt_q == CNT_W'(MAX_PEERS - 1)) begin
				init_done_q <= 1'b1;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_comb begin
		mem_we    = !init_done_q || wr_en;
		mem_addr  = init_done_q ? wr_addr : clr_cnt_q[IDX_W-1:0];
		mem_wdata = init_done_q ? wr_data : RESET_WEIGHT;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data   = rd_data_q;
	assign init_done = init_done_q;

endmodule

@@ hw/rtl/wrps_scan_core.sv @@
module wrps_scan_core #(
	parameter int MAX_PEERS   = wrps_pkg::DEF_MAX_PEERS,
	parameter int WEIGHT_BITS = wrps_pkg::DEF_WEIGHT_BITS,
	localparam int IDX_W      = $clog2(MAX_PEERS),
	localparam int CNT_W      = $clog2(MAX_PEERS + 1)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wrps_pkg::cfg_state_t                  cfg,
	input  logic                                  init_done,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  in_opcode,
	input  logic [wrps_pkg::PEER_IDX_BITS-1:0]    in_peer_index,
	input  logic [wrps_pkg::IN_WEIGHT_BITS-1:0]   in_weight,
	input  logic [wrps_pkg::FRAC_BITS-1:0]        in_fraction,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output logic [wrps_pkg::PEER_IDX_BITS-1:0]    res_chosen,
	output wrps_pkg::status_t                     res_status,
	output logic                                  wr_en,
	output logic [IDX_W-1:0]                      wr_addr,
	output logic [WEIGHT_BITS-1:0]                wr_data,
	output logic                                  rd_en,
	output logic [IDX_W-1:0]                      rd_addr,
	input  logic [WEIGHT_BITS-1:0]                rd_data
);

	localparam int TOT_W  = WEIGHT_BITS + IDX_W;
	localparam int PROD_W = TOT_W + wrps_pkg::FRAC_BITS;
	localparam int XW     = (IDX_W > wrps_pkg::PEER_IDX_BITS) ? IDX_W : wrps_pkg::PEER_IDX_BITS;
	localparam int WX     = (WEIGHT_BITS > wrps_pkg::IN_WEIGHT_BITS) ?
		WEIGHT_BITS : wrps_pkg::IN_WEIGHT_BITS;
	localparam int PC_W   = (CNT_W > wrps_pkg::PEER_COUNT_BITS) ? CNT_W : wrps_pkg::PEER_COUNT_BITS;

	wrps_pkg::scan_state_t state_q, state_d;

	logic                           own_written_q;
	logic                           total_valid_q;
	logic [TOT_W-1:0]               total_q;
	logic [TOT_W-1:0]               acc_q;
	logic [PROD_W-1:0]              prod_q;
	logic [wrps_pkg::FRAC_BITS-1:0] frac_q;
	logic [CNT_W-1:0]               issue_q;
	logic                           rd_vld_s1;
	logic [IDX_W-1:0]               rd_idx_s1;
	logic [wrps_pkg::PEER_IDX_BITS-1:0] chosen_q;
	wrps_pkg::status_t              status_q;

	logic [PC_W-1:0]        pc_x;
	logic [CNT_W-1:0]       n_use;
	logic [XW-1:0]          own_x;
	logic [XW-1:0]          pick_x;
	logic [XW-1:0]          idx_x;
	logic [WX-1:0]          w_x;
	logic [WEIGHT_BITS-1:0] w_sat;
	logic [WEIGHT_BITS-1:0] eff_weight;
	logic [TOT_W-1:0]       acc_next;
	logic [PROD_W-1:0]      acc_scaled;
	logic                   last;
	logic                   hit;
	logic                   in_fire;
	logic                   upd_fire;
	logic                   upd_in_range;

	// Peer count of zero counts as one, anything above the storage as the storage.
	always_comb begin
		pc_x = PC_W'(cfg.peer_count);
		if (pc_x == '0) begin
			n_use = CNT_W'(1);
		end else if (pc_x > PC_W'(MAX_PEERS)) begin
			n_use = CNT_W'(MAX_PEERS);
		end else begin
			n_use = pc_x[CNT_W-1:0];
		end
	end

	always_comb begin
		own_x        = XW'(cfg.own_rank);
		pick_x       = XW'(rd_idx_s1);
		idx_x        = XW'(in_peer_index);
		w_x          = WX'(in_weight);
		w_sat        = (w_x > WX'({WEIGHT_BITS{1'b1}})) ? {WEIGHT_BITS{1'b1}} :
			w_x[WEIGHT_BITS-1:0];
		upd_in_range = 32'(in_peer_index) < MAX_PEERS;
		// The own entry reads as zero until software gives it a weight.
		eff_weight   = (pick_x == own_x && !own_written_q) ? '0 : rd_data;
		acc_next     = acc_q + TOT_W'(eff_weight);
		acc_scaled   = {acc_next, {wrps_pkg::FRAC_BITS{1'b0}}};
		last         = CNT_W'(rd_idx_s1) == n_use - 1'b1;
		hit          = acc_scaled > prod_q;
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = (state_q == wrps_pkg::ST_IDLE) && init_done;
		res_valid = (state_q == wrps_pkg::ST_DONE);
		rd_en     = 1'b0;
		case (state_q)
			wrps_pkg::ST_IDLE: begin
				if (in_valid && in_ready) begin
					if (in_opcode == wrps_pkg::OP_UPDATE) begin
						state_d = wrps_pkg::ST_DONE;
					end else if (total_valid_q) begin
						state_d = wrps_pkg::ST_MUL;
					end else begin
						state_d = wrps_pkg::ST_SUM;
					end
				end
			end
			wrps_pkg::ST_SUM: begin
				rd_en = issue_q < n_use;
				if (rd_vld_s1 && last) begin
					state_d = wrps_pkg::ST_MUL;
				end
			end
			wrps_pkg::ST_MUL: begin
				state_d = (total_q == '0) ? wrps_pkg::ST_DONE : wrps_pkg::ST_SEARCH;
			end
			wrps_pkg::ST_SEARCH: begin
				rd_en = issue_q < n_use;
				if (rd_vld_s1 && (hit || last)) begin
					state_d = wrps_pkg::ST_DONE;
				end
			end
			wrps_pkg::ST_DONE: begin
				if (res_ready) begin
					state_d = wrps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wrps_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_fire  = in_valid && in_ready;
	assign upd_fire = in_fire && (in_opcode == wrps_pkg::OP_UPDATE);
	assign rd_addr  = issue_q[IDX_W-1:0];
	assign wr_en    = upd_fire && upd_in_range;
	assign wr_addr  = idx_x[IDX_W-1:0];
	assign wr_data  = w_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= wrps_pkg::ST_IDLE;
			own_written_q <= 1'b0;
			total_valid_q <= 1'b0;
			rd_vld_s1     <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (cfg.own_rank_wr) begin
				own_written_q <= 1'b0;
			end else if (wr_en && in_peer_index == cfg.own_rank) begin
				own_written_q <= 1'b1;
			end
			// Any change of weights or group makes the cached total stale.
			if (cfg.any_wr || wr_en) begin
				total_valid_q <= 1'b0;
			end else if (state_q == wrps_pkg::ST_SUM && rd_vld_s1 && last) begin
				total_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		if (rd_en) begin
			issue_q <= issue_q + 1'b1;
		end
		case (state_q)
			wrps_pkg::ST_IDLE: begin
				if (in_fire) begin
					frac_q   <= in_fraction;
					issue_q  <= '0;
					acc_q    <= '0;
					chosen_q <= '0;
					status_q <= wrps_pkg::STATUS_OK;
				end
			end
			wrps_pkg::ST_SUM: begin
				if (rd_vld_s1) begin
					acc_q <= acc_next;
					if (last) begin
						total_q <= acc_next;
					end
				end
			end
			wrps_pkg::ST_MUL: begin
				issue_q <= '0;
				acc_q   <= '0;
				prod_q  <= PROD_W'(frac_q) * PROD_W'(total_q);
				if (total_q == '0) begin
					status_q <= wrps_pkg::STATUS_ZERO_TOTAL;
				end
			end
			wrps_pkg::ST_SEARCH: begin
				if (rd_vld_s1) begin
					acc_q <= acc_next;
					if (hit || last) begin
						if (pick_x == own_x) begin
							status_q <= wrps_pkg::STATUS_OWN_RANK;
						end else begin
							chosen_q <= pick_x[wrps_pkg::PEER_IDX_BITS-1:0];
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign res_chosen = chosen_q;
	assign res_status = status_q;

endmodule

@@ hw/rtl/weighted_random_peer_select.sv @@
// Channel   Direction  Handshake              Payload
// s_        in         s_tvalid / s_tready    s_tdata: peer_index, weight, random_fraction
//                                             s_tuser: opcode
// m_        out        m_tvalid / m_tready    m_tdata: chosen_peer; m_tuser: status
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A select reads one weight a cycle from the weight memory. When the total must first
// be summed again after an update or a register write, it reads the n peers in use
// once more before the search.
// After reset a clearing pass loads every weight; s_tready stays low until it ends,
// while register writes are taken at once.
// A finished result sits in the output register, so the next transaction is accepted
// while m_tready is low.
module weighted_random_peer_select #(
	parameter int MAX_PEERS   = wrps_pkg::DEF_MAX_PEERS,
	parameter int WEIGHT_BITS = wrps_pkg::DEF_WEIGHT_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [5:0] peer_index, [21:6] weight, [37:22] random_fraction, [39:38] zero
	input  logic [wrps_pkg::S_TDATA_BITS-1:0]   s_tdata,
	// [0] opcode
	input  logic [0:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [5:0] chosen_peer, [7:6] zero
	output logic [wrps_pkg::M_TDATA_BITS-1:0]   m_tdata,
	// [1:0] status
	output logic [wrps_pkg::STATUS_BITS-1:0]    m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wrps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [wrps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int IDX_W = $clog2(MAX_PEERS);

	logic [wrps_pkg::PEER_COUNT_BITS-1:0] peer_count_q;
	logic [wrps_pkg::PEER_IDX_BITS-1:0]   own_rank_q;
	logic                                 cfg_fire;
	wrps_pkg::cfg_state_t                 cfg;

	logic                                 init_done;
	logic                                 res_valid;
	logic                                 res_ready;
	logic [wrps_pkg::PEER_IDX_BITS-1:0]   res_chosen;
	wrps_pkg::status_t                    res_status;
	logic                                 wr_en;
	logic [IDX_W-1:0]                     wr_addr;
	logic [WEIGHT_BITS-1:0]               wr_data;
	logic                                 rd_en;
	logic [IDX_W-1:0]                     rd_addr;
	logic [WEIGHT_BITS-1:0]               rd_data;

	logic                                 m_tvalid_q;
	logic [wrps_pkg::PEER_IDX_BITS-1:0]   m_chosen_q;
	logic [wrps_pkg::STATUS_BITS-1:0]     m_status_q;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_count_q <= wrps_pkg::PEER_COUNT_BITS'(64);
			own_rank_q   <= '0;
		end else if (cfg_fire) begin
			case (cfg_index)
				wrps_pkg::REG_PEER_COUNT: peer_count_q <= cfg_data;
				wrps_pkg::REG_OWN_RANK:   own_rank_q <= cfg_data[wrps_pkg::PEER_IDX_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.peer_count  = peer_count_q;
		cfg.own_rank    = own_rank_q;
		cfg.own_rank_wr = cfg_fire && (cfg_index == wrps_pkg::REG_OWN_RANK);
		cfg.any_wr      = cfg_fire;
	end

	wrps_weight_store #(
		.MAX_PEERS  (MAX_PEERS),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.init_done(init_done)
	);

	wrps_scan_core #(
		.MAX_PEERS  (MAX_PEERS),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.init_done    (init_done),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_opcode    (s_tuser[0]),
		.in_peer_index(s_tdata[5:0]),
		.in_weight    (s_tdata[21:6]),
		.in_fraction  (s_tdata[37:22]),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_chosen   (res_chosen),
		.res_status   (res_status),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_chosen_q <= res_chosen;
			m_status_q <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, m_chosen_q};
	assign m_tuser  = m_status_q;

endmodule

@@ hw/rtl/wrps_checker.sv @@
module wrps_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [wrps_pkg::M_TDATA_BITS-1:0]   m_tdata,
	input logic [wrps_pkg::STATUS_BITS-1:0]    m_tuser
);

	// The block never accepts input in the cycle right after it accepted a transaction.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on two consecutive cycles");

	// A result is only produced while an item is in flight.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while the block was idle");

	// A failed select never names a peer.
	a_failure_zero_peer: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != wrps_pkg::STATUS_OK |-> m_tdata[5:0] == 6'd0)
		else $error("nonzero peer returned with a failure status");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output dropped before it was taken");

endmodule

bind weighted_random_peer_select wrps_checker u_wrps_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	localparam int PEERS = wrps_pkg::DEF_MAX_PEERS;
	localparam int IDLE_LIMIT = 3000;
	localparam int PHASE_ITEMS = 250;

	typedef struct {
		bit [wrps_pkg::PEER_IDX_BITS-1:0] peer;
		wrps_pkg::status_t                status;
	} pick_t;

	// Tracks the weight table and predicts the answer to every accepted transaction.
	class peer_pick_scoreboard;
		bit [wrps_pkg::DEF_WEIGHT_BITS-1:0] weights [PEERS];
		bit                                 own_written;
		bit [wrps_pkg::PEER_COUNT_BITS-1:0] peer_count;
		bit [wrps_pkg::PEER_IDX_BITS-1:0]   own_rank;
		pick_t                              pending_picks [$];
		int                                 errors;

		function new();
			foreach (weights[i])
				weights[i] = wrps_pkg::DEF_WEIGHT_BITS'(wrps_pkg::ONE_UNIT);
			own_written = 1'b0;
			peer_count = wrps_pkg::PEER_COUNT_BITS'(PEERS);
			own_rank = '0;
			errors = 0;
		endfunction

		function int unsigned peers_in_use();
			if (peer_count == 0)
				return 1;
			if (peer_count > PEERS)
				return PEERS;
			return peer_count;
		endfunction

		// The own entry counts as zero until it has been written since the last rank change.
		function longint unsigned eff_weight(int unsigned i);
			if (i == own_rank && !own_written)
				return 0;
			return weights[i];
		endfunction

		function void write_reg(wrps_pkg::reg_index_t idx,
				bit [wrps_pkg::CFG_DATA_BITS-1:0] data);
			case (idx)
				wrps_pkg::REG_PEER_COUNT: begin
					peer_count = data[wrps_pkg::PEER_COUNT_BITS-1:0];
				end
				wrps_pkg::REG_OWN_RANK: begin
					own_rank = data[wrps_pkg::PEER_IDX_BITS-1:0];
					own_written = 1'b0;
				end
				default: begin
				end
			endcase
		endfunction

		function void accept_item(wrps_pkg::opcode_t op, bit [wrps_pkg::PEER_IDX_BITS-1:0] idx,
				bit [wrps_pkg::IN_WEIGHT_BITS-1:0] w, bit [wrps_pkg::FRAC_BITS-1:0] r);
			int unsigned n;
			int unsigned pick;
			longint unsigned total;
			longint unsigned threshold;
			longint unsigned running;
			pick_t res;
			res.peer = '0;
			res.status = wrps_pkg::STATUS_OK;
			n = peers_in_use();
			if (op == wrps_pkg::OP_UPDATE) begin
				weights[idx] = w;
				if (idx == own_rank)
					own_written = 1'b1;
			end else begin
				total = 0;
				for (int unsigned i = 0; i < n; i++)
					total += eff_weight(i);
				if (total == 0) begin
					res.status = wrps_pkg::STATUS_ZERO_TOTAL;
				end else begin
					// First peer whose running sum, scaled by 2^16, passes r times the total.
					threshold = longint'(r) * total;
					running = 0;
					pick = n - 1;
					for (int unsigned i = 0; i < n; i++) begin
						running += eff_weight(i);
						if ((running << wrps_pkg::FRAC_BITS) > threshold) begin
							pick = i;
							break;
						end
					end
					if (pick == own_rank)
						res.status = wrps_pkg::STATUS_OWN_RANK;
					else
						res.peer = pick[wrps_pkg::PEER_IDX_BITS-1:0];
				end
			end
			pending_picks = {pending_picks, res};
		endfunction

		function void check_pick(logic [wrps_pkg::PEER_IDX_BITS-1:0] peer,
				logic [wrps_pkg::STATUS_BITS-1:0] status);
			pick_t want;
			if (pending_picks.size() == 0) begin
				$display("%0t: unexpected result, chosen_peer %0d status %0d", $time, peer, status);
				errors++;
				return;
			end
			want = pending_picks.pop_front();
			if (peer !== want.peer) begin
				$display("%0t: chosen_peer expected %0d actual %0d", $time, want.peer, peer);
				errors++;
			end
			if (status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [wrps_pkg::S_TDATA_BITS-1:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [wrps_pkg::M_TDATA_BITS-1:0] m_tdata;
	logic [wrps_pkg::STATUS_BITS-1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [wrps_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [wrps_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	peer_pick_scoreboard picks = new();
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int unsigned rx_hold = 0;
	int unsigned idle_cycles = 0;

	weighted_random_peer_select dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly no gap, some short ones and a few long ones; never a gap when steady.
	function automatic int unsigned next_gap(bit steady);
		int unsigned roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return 0;
		if (roll < 9)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			picks.check_pick(m_tdata[wrps_pkg::PEER_IDX_BITS-1:0], m_tuser);
		if (rx_hold > 0)
			rx_hold--;
		else
			rx_hold = next_gap(rx_steady);
		m_tready <= (rx_hold == 0);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(wrps_pkg::opcode_t op, bit [wrps_pkg::PEER_IDX_BITS-1:0] idx,
			bit [wrps_pkg::IN_WEIGHT_BITS-1:0] w, bit [wrps_pkg::FRAC_BITS-1:0] r);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {2'b00, r, w, idx};
		do
			@(posedge clk);
		while (!s_tready);
		picks.accept_item(op, idx, w, r);
		gap = next_gap(tx_steady);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_picks();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (picks.pending_picks.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_reg(wrps_pkg::reg_index_t idx, bit [wrps_pkg::CFG_DATA_BITS-1:0] data);
		drain_picks();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		picks.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		wrps_pkg::opcode_t op;
		bit [wrps_pkg::PEER_IDX_BITS-1:0] idx;
		bit [wrps_pkg::IN_WEIGHT_BITS-1:0] wt;
		bit [wrps_pkg::FRAC_BITS-1:0] frac;
		bit [wrps_pkg::CFG_DATA_BITS-1:0] count_val;
		bit [wrps_pkg::CFG_DATA_BITS-1:0] rank_val;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values, own entry unwritten, extremes of r and of the weight.
		set_reg(wrps_pkg::REG_PEER_COUNT, 7'd64);
		set_reg(wrps_pkg::REG_OWN_RANK, 7'd0);
		send_item(wrps_pkg::OP_SELECT, 6'd0, 16'h0000, 16'h0000);
		send_item(wrps_pkg::OP_SELECT, 6'd63, 16'hFFFF, 16'hFFFF);
		send_item(wrps_pkg::OP_UPDATE, 6'd63, 16'hFFFF, 16'h0000);
		send_item(wrps_pkg::OP_SELECT, 6'd0, 16'h0000, 16'hFFFF);
		send_item(wrps_pkg::OP_UPDATE, 6'd0, 16'h8000, 16'h1234);
		send_item(wrps_pkg::OP_SELECT, 6'd0, 16'h0000, 16'h0000);
		send_item(wrps_pkg::OP_UPDATE, 6'd5, 16'h0000, 16'h0000);
		send_item(wrps_pkg::OP_SELECT, 6'd0, 16'h0000, 16'h0100);

		// Two peers: zero total, then only the own entry carries weight.
		set_reg(wrps_pkg::REG_PEER_COUNT, 7'd2);
		set_reg(wrps_pkg::REG_OWN_RANK, 7'd1);
		send_item(wrps_pkg::OP_UPDATE, 6'd0, 16'h0000, 16'h0000);
		send_item(wrps_pkg::OP_SELECT, 6'd0, 16'h0000, 16'h4000);
		send_item(wrps_pkg::OP_UPDATE, 6'd1, 16'h0001, 16'h0000);
		send_item(wrps_pkg::OP_SELECT, 6'd0, 16'h0000, 16'hFFFF);
		send_item(wrps_pkg::OP_UPDATE, 6'd40, 16'h0007, 16'hFFFF);

		// A count of zero means one peer; the own rank lies outside the group.
		set_reg(wrps_pkg::REG_PEER_COUNT, 7'd0);
		set_reg(wrps_pkg::REG_OWN_RANK, 7'd63);
		send_item(wrps_pkg::OP_SELECT, 6'd0, 16'h0000, 16'h8000);
		send_item(wrps_pkg::OP_UPDATE, 6'd0, 16'hFFFF, 16'h0000);
		send_item(wrps_pkg::OP_SELECT, 6'd0, 16'h0000, 16'h8000);

		// A count above the storage is clipped; the upper rank bit is dropped.
		set_reg(wrps_pkg::REG_PEER_COUNT, 7'd127);
		set_reg(wrps_pkg::REG_OWN_RANK, 7'h45);
		send_item(wrps_pkg::OP_SELECT, 6'd0, 16'h0000, 16'hFFFF);
		send_item(wrps_pkg::OP_SELECT, 6'd0, 16'h0000, 16'h0000);
		set_reg(wrps_pkg::REG_PEER_COUNT, 7'd41);
		send_item(wrps_pkg::OP_SELECT, 6'd0, 16'h0000, 16'hFFF0);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin count_val = 7'd64; rank_val = 7'd0; end
				1: begin count_val = 7'd1; rank_val = 7'd0; end
				2: begin count_val = 7'd0; rank_val = 7'd63; end
				3: begin count_val = 7'd127; rank_val = 7'h45; end
				4: begin count_val = 7'd2; rank_val = 7'd1; end
				5: begin count_val = 7'd64; rank_val = 7'd63; end
				6: begin
					count_val = wrps_pkg::CFG_DATA_BITS'($urandom_range(3, 8));
					rank_val = wrps_pkg::CFG_DATA_BITS'($urandom_range(0, 127));
				end
				default: begin
					count_val = wrps_pkg::CFG_DATA_BITS'($urandom_range(65, 127));
					rank_val = wrps_pkg::CFG_DATA_BITS'($urandom_range(0, 63));
				end
			endcase
			set_reg(wrps_pkg::REG_PEER_COUNT, count_val);
			set_reg(wrps_pkg::REG_OWN_RANK, rank_val);
			tx_steady = (ph % 3 == 1);
			rx_steady = (ph % 4 == 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				op = wrps_pkg::opcode_t'($urandom_range(0, 1));
				if ($urandom_range(0, 3) != 0)
					idx = wrps_pkg::PEER_IDX_BITS'($urandom_range(0, picks.peers_in_use() - 1));
				else
					idx = wrps_pkg::PEER_IDX_BITS'($urandom);
				// Zero weights are common so that small groups reach a zero total.
				case ($urandom_range(0, 9))
					0, 1, 2: wt = '0;
					3: wt = '1;
					4, 5, 6: wt = wrps_pkg::IN_WEIGHT_BITS'($urandom_range(1, 1024));
					default: wt = wrps_pkg::IN_WEIGHT_BITS'($urandom);
				endcase
				case ($urandom_range(0, 9))
					0: frac = '0;
					1: frac = '1;
					default: frac = wrps_pkg::FRAC_BITS'($urandom);
				endcase
				send_item(op, idx, wt, frac);
				if (i == PHASE_ITEMS / 2)
					drain_picks();
			end
		end

		drain_picks();
		repeat (200) @(posedge clk);
		if (picks.pending_picks.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				picks.pending_picks.size());
			picks.errors++;
		end
		if (picks.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/wrps_pkg.sv
hw/rtl/wrps_weight_store.sv
hw/rtl/wrps_scan_core.sv
hw/rtl/weighted_random_peer_select.sv
hw/rtl/wrps_checker.sv
tb/testbench.sv
